// ===== src/linear_interp_grid_resampler_macros.svh =====
// Assertion macros shared by the grid resampler RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef LINEAR_INTERP_GRID_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_GRID_RESAMPLER_MACROS_SVH

// property must hold at every clock edge
`define LIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge
`define LIR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/lir_pkg.sv =====
// Shared types and constants for the linear grid resampler.
// No dependencies; imported by lir_front, lir_back and the top level.
`default_nettype none
package lir_pkg;
	localparam int unsigned NVAL          = 4;
	localparam int unsigned MAX_GRID_DEF  = 64;
	localparam logic [31:0] STEP_RST      = 32'h0001_0000;
	localparam logic [6:0]  COUNT_RST     = 7'd64;

	typedef enum logic [0:0] {
		REG_GRID_STEP  = 1'b0,
		REG_GRID_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]                pos;
		logic [NVAL-1:0][31:0]      vals;
		logic                       last;
	} knot_t;
endpackage
`default_nettype wire

// ===== src/lir_front.sv =====
// Front end: two-entry knot queue between the input channel and the engine.
// Depends on lir_pkg (knot_t) and the assertion macros.
`default_nettype none
`include "linear_interp_grid_resampler_macros.svh"
module lir_front import lir_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  knot_t in_knot,
	output logic  q_valid,
	input  logic  q_pop,
	output knot_t q_knot
);
	knot_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_knot   = slot_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_knot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`LIR_NEVER(a_front_cnt, cnt_q == 2'd3, "knot queue count out of range")
endmodule
`default_nettype wire

// ===== src/lir_muldiv.sv =====
// Shared serial unit: |a|*|b| by shift-add, then restoring division by d.
// Depends on the assertion macros; one product bit or quotient bit a cycle.
`default_nettype none
`include "linear_interp_grid_resampler_macros.svh"
module lir_muldiv #(
	parameter int unsigned AW = 39
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [32:0]   b,
	input  logic [31:0]   d,
	output logic          busy,
	output logic          done,
	output logic [32:0]   quo,
	output logic          over
);
	localparam int unsigned PW    = AW + 33;
	localparam int unsigned CNT_W = $clog2(PW + 1);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} md_state_t;

	md_state_t       state_q;
	logic [PW-1:0]   acc_q;
	logic [PW-1:0]   a_sh_q;
	logic [32:0]     b_sh_q;
	logic [31:0]     d_q;
	logic [31:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic            done_q;
	logic [32:0]     trial;
	logic            ge;

	assign trial = {rem_q, acc_q[PW-1]};
	assign ge    = (trial >= {1'b0, d_q});
	assign busy  = (state_q != M_IDLE);
	assign done  = done_q;
	assign quo   = acc_q[32:0];
	assign over  = |acc_q[PW-1:33];

	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: begin
				if (start) begin
					acc_q  <= '0;
					a_sh_q <= PW'(a);
					b_sh_q <= b;
					d_q    <= d;
				end
			end
			M_MUL: begin
				if (b_sh_q[0]) begin
					acc_q <= acc_q + a_sh_q;
				end
				a_sh_q <= {a_sh_q[PW-2:0], 1'b0};
				b_sh_q <= {1'b0, b_sh_q[32:1]};
				rem_q  <= '0;
			end
			M_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, d_q}) : trial[31:0];
				acc_q <= {acc_q[PW-2:0], ge};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						cnt_q   <= CNT_W'(33);
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (cnt_q == CNT_W'(1)) begin
						cnt_q   <= CNT_W'(PW);
						state_q <= M_DIV;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	`LIR_ASSERT(a_md_done_idle, done_q |-> (state_q == M_IDLE), "done while unit busy")
endmodule
`default_nettype wire

// ===== src/lir_back.sv =====
// Back end: segment state, grid walk, per-value interpolation and result register.
// Depends on lir_pkg, lir_muldiv and the assertion macros.
`default_nettype none
`include "linear_interp_grid_resampler_macros.svh"
module lir_back import lir_pkg::*; #(
	parameter int unsigned MAX_GRID_POINTS = MAX_GRID_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_GRID_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  knot_t              q_knot,
	input  logic [31:0]        grid_step,
	input  logic [6:0]         grid_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   grid_index,
	output logic signed [31:0] u_out,
	output logic signed [31:0] k_out,
	output logic signed [31:0] ep_out,
	output logic signed [31:0] v2_out,
	output logic               end_of_run,
	output logic               grid_done
);
	localparam int unsigned NG_W = $clog2(MAX_GRID_POINTS + 1);
	localparam int unsigned G_W  = 32 + NG_W;
	localparam int unsigned CW   = (NG_W > 7) ? NG_W : 7;
	localparam int unsigned VI_W = $clog2(NVAL);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_GCALC = 5'b00010,
		S_CHECK = 5'b00100,
		S_VAL   = 5'b01000,
		S_WAIT  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [31:0]       prev_pos_q;
	logic [31:0]       cur_pos_q;
	logic [31:0]       prev_vals_q [NVAL];
	logic [31:0]       cur_vals_q  [NVAL];
	logic [1:0]        ks_q;
	logic [NG_W-1:0]   next_grid_q;
	logic              last_q;
	logic [G_W-1:0]    g_q;
	logic [VI_W-1:0]   vidx_q;
	logic              neg_q;
	logic [31:0]       u1_q;
	logic [31:0]       res_vals_q [NVAL];
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_gd_q;
	logic              have_res_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [31:0]       out_vals_q [NVAL];
	logic              out_eor_q;
	logic              out_gd_q;

	logic [CW-1:0]     gc_ext;
	logic [CW-1:0]     cnt_c;
	logic [NG_W-1:0]   count;
	logic              out_free;
	logic              emit;
	logic [31:0]       u1;
	logic [31:0]       u2;
	logic signed [G_W:0] dg;
	logic signed [32:0]  du;
	logic [G_W-1:0]    a_mag;
	logic [32:0]       b_mag;
	logic              trivial;
	logic [31:0]       triv_val;
	logic              md_start;
	logic              md_busy;
	logic              md_done;
	logic [32:0]       md_quo;
	logic              md_over;
	logic signed [34:0] sum;
	logic [31:0]       wait_val;
	logic              val_wr;
	logic [31:0]       val_data;

	assign gc_ext = CW'(grid_count);
	assign cnt_c  = (gc_ext > CW'(MAX_GRID_POINTS)) ? CW'(MAX_GRID_POINTS) : gc_ext;
	assign count  = NG_W'(cnt_c);

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (next_grid_q < count) &&
	                  (last_q || (ks_q == 2'd2 && g_q <= G_W'(cur_pos_q)));
	assign q_pop    = (state_q == S_IDLE);

	// Segment terms for the value being worked on
	assign u1    = prev_vals_q[vidx_q];
	assign u2    = cur_vals_q[vidx_q];
	assign dg    = $signed({1'b0, g_q}) - $signed({{(NG_W + 1){1'b0}}, prev_pos_q});
	assign du    = $signed({u2[31], u2}) - $signed({u1[31], u1});
	assign a_mag = dg[G_W] ? G_W'(-dg) : dg[G_W-1:0];
	assign b_mag = du[32] ? 33'(-du) : du[32:0];

	always_comb begin
		trivial  = 1'b1;
		triv_val = u2;
		if (ks_q != 2'd2 || cur_pos_q <= prev_pos_q) begin
			triv_val = u2;
		end else if (a_mag == '0 || b_mag == '0) begin
			triv_val = u1;
		end else begin
			trivial = 1'b0;
		end
	end

	assign md_start = (state_q == S_VAL) && !trivial;

	lir_muldiv #(
		.AW (G_W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (a_mag),
		.b      (b_mag),
		.d      (cur_pos_q - prev_pos_q),
		.busy   (md_busy),
		.done   (md_done),
		.quo    (md_quo),
		.over   (md_over)
	);

	always_comb begin
		sum = neg_q ? ($signed({{3{u1_q[31]}}, u1_q}) - $signed({2'b00, md_quo}))
		            : ($signed({{3{u1_q[31]}}, u1_q}) + $signed({2'b00, md_quo}));
		if (md_over) begin
			wait_val = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (sum > 35'sh0_7FFF_FFFF) begin
			wait_val = 32'h7FFF_FFFF;
		end else if (sum < -35'sh0_8000_0000) begin
			wait_val = 32'h8000_0000;
		end else begin
			wait_val = sum[31:0];
		end
	end

	assign val_wr   = ((state_q == S_VAL) && trivial) || ((state_q == S_WAIT) && md_done);
	assign val_data = (state_q == S_WAIT) ? wait_val : triv_val;

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_GCALC) begin
			g_q <= G_W'(G_W'(next_grid_q) + G_W'(1)) * G_W'(grid_step);
		end
		if (md_start) begin
			neg_q <= dg[G_W] ^ du[32];
			u1_q  <= u1;
		end
		if (val_wr) begin
			res_vals_q[vidx_q] <= val_data;
			if (vidx_q == VI_W'(NVAL - 1)) begin
				res_idx_q <= IDX_W'(next_grid_q);
				res_gd_q  <= (next_grid_q + NG_W'(1) == count);
			end
		end
		if (state_q == S_CHECK && have_res_q && out_free) begin
			out_idx_q  <= res_idx_q;
			out_vals_q <= res_vals_q;
			out_eor_q  <= !emit;
			out_gd_q   <= res_gd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_pos_q  <= '0;
			cur_pos_q   <= '0;
			prev_vals_q <= '{default: '0};
			cur_vals_q  <= '{default: '0};
			ks_q        <= 2'd0;
			next_grid_q <= '0;
			last_q      <= 1'b0;
			vidx_q      <= '0;
			have_res_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CHECK && have_res_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						prev_pos_q <= cur_pos_q;
						cur_pos_q  <= q_knot.pos;
						for (int v = 0; v < NVAL; v++) begin
							prev_vals_q[v] <= cur_vals_q[v];
							cur_vals_q[v]  <= q_knot.vals[v];
						end
						if (ks_q != 2'd2) begin
							ks_q <= ks_q + 2'd1;
						end
						last_q  <= q_knot.last;
						state_q <= S_GCALC;
					end
				end
				S_GCALC: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!have_res_q || out_free) begin
						if (have_res_q) begin
							have_res_q <= 1'b0;
						end
						if (emit) begin
							vidx_q  <= '0;
							state_q <= S_VAL;
						end else begin
							// a last knot ends the run: back to the reset picture
							if (last_q) begin
								prev_pos_q  <= '0;
								cur_pos_q   <= '0;
								prev_vals_q <= '{default: '0};
								cur_vals_q  <= '{default: '0};
								ks_q        <= 2'd0;
								next_grid_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_VAL, S_WAIT: begin
					if (md_start) begin
						state_q <= S_WAIT;
					end
					if (val_wr) begin
						if (vidx_q == VI_W'(NVAL - 1)) begin
							next_grid_q <= next_grid_q + NG_W'(1);
							have_res_q  <= 1'b1;
							state_q     <= S_GCALC;
						end else begin
							vidx_q  <= vidx_q + VI_W'(1);
							state_q <= S_VAL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign grid_index = out_idx_q;
	assign u_out      = $signed(out_vals_q[0]);
	assign k_out      = $signed(out_vals_q[1]);
	assign ep_out     = $signed(out_vals_q[2]);
	assign v2_out     = $signed(out_vals_q[3]);
	assign end_of_run = out_eor_q;
	assign grid_done  = out_gd_q;

	`LIR_ASSERT(a_idle_no_res, (state_q == S_IDLE) |-> !have_res_q, "result left over at idle")
	`LIR_ASSERT(a_wait_md, (state_q == S_WAIT) |-> (md_busy || md_done), "waiting on idle unit")
	`LIR_NEVER(a_grid_range, next_grid_q > NG_W'(MAX_GRID_POINTS), "grid index past maximum")
endmodule
`default_nettype wire

// ===== src/linear_interp_grid_resampler.sv =====
// Top level of the linear grid resampler: config registers, knot queue, engine.
// Depends on lir_pkg, lir_front, lir_back (and lir_muldiv below it).
//
//  channel  handshake              payload
//  in       in_valid / in_stall    knot_pos, u_val, k_val, ep_val, v2_val, last_knot
//  out      out_valid / out_stall  grid_index, u_out, k_out, ep_out, v2_out,
//                                  end_of_run, grid_done
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A knot that emits nothing passes the engine states S_IDLE, S_GCALC and S_CHECK;
// each emitted grid point passes S_GCALC and S_CHECK and then, per value, S_VAL
// alone when it is a copy, or S_VAL and S_WAIT on the shared serial multiply/divide
// unit. The queue takes two knots while the engine works. Reset is immediate:
// no clearing pass. The output register holds a result while out_stall is high.
`default_nettype none
module linear_interp_grid_resampler import lir_pkg::*; #(
	parameter int unsigned MAX_GRID_POINTS = MAX_GRID_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_GRID_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        knot_pos,
	input  logic signed [31:0] u_val,
	input  logic signed [31:0] k_val,
	input  logic signed [31:0] ep_val,
	input  logic signed [31:0] v2_val,
	input  logic               last_knot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   grid_index,
	output logic signed [31:0] u_out,
	output logic signed [31:0] k_out,
	output logic signed [31:0] ep_out,
	output logic signed [31:0] v2_out,
	output logic               end_of_run,
	output logic               grid_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [31:0] grid_step_q;
	logic [6:0]  grid_count_q;
	knot_t       in_knot;
	knot_t       q_knot;
	logic        q_valid;
	logic        q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_step_q  <= STEP_RST;
			grid_count_q <= COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_STEP:  grid_step_q  <= cfg_data;
				REG_GRID_COUNT: grid_count_q <= cfg_data[6:0];
				default:        grid_step_q  <= grid_step_q;
			endcase
		end
	end

	assign in_knot.pos     = knot_pos;
	assign in_knot.vals[0] = u_val;
	assign in_knot.vals[1] = k_val;
	assign in_knot.vals[2] = ep_val;
	assign in_knot.vals[3] = v2_val;
	assign in_knot.last    = last_knot;

	lir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_knot  (in_knot),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_knot   (q_knot)
	);

	lir_back #(
		.MAX_GRID_POINTS (MAX_GRID_POINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_knot     (q_knot),
		.grid_step  (grid_step_q),
		.grid_count (grid_count_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grid_index (grid_index),
		.u_out      (u_out),
		.k_out      (k_out),
		.ep_out     (ep_out),
		.v2_out     (v2_out),
		.end_of_run (end_of_run),
		.grid_done  (grid_done)
	);
endmodule
`default_nettype wire
